@@ design/assert_macros.svh @@
// assert_macros.svh: concurrent assertion wrappers for the filter.
// Define NO_ASSERTIONS to compile every check out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check on every rising edge, held off while reset is asserted.
`define TLEF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every rising edge, reset included.
`define TLEF_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLEF_ASSERT(lbl, clk, rst_n, prop, msg)
`define TLEF_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

@@ design/tlef_pkg.sv @@
// tlef_pkg: shared constants, types and codes of the line-numbering filter.
// No dependencies; every design module imports it, the channel interfaces do not.
package tlef_pkg;

  localparam int NumDigits  = 6;
  localparam int MaxResults = NumDigits + 5;
  localparam int PosW       = $clog2(MaxResults);
  localparam int DigIdxW    = (NumDigits > 1) ? $clog2(NumDigits) : 1;
  localparam int SfxMax     = 4;
  localparam int SfxIdxW    = $clog2(SfxMax);
  localparam int SfxLenW    = $clog2(SfxMax + 1);
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  typedef logic [7:0] char_t;

  localparam char_t ChNl     = 8'h0A;
  localparam char_t ChTab    = 8'h09;
  localparam char_t ChSpace  = 8'h20;
  localparam char_t ChZero   = 8'h30;
  localparam char_t ChDollar = 8'h24;
  localparam char_t ChCaret  = 8'h5E;
  localparam char_t ChUpperI = 8'h49;
  localparam char_t ChUpperM = 8'h4D;
  localparam char_t ChDash   = 8'h2D;
  localparam char_t ChQuery  = 8'h3F;
  localparam char_t CtrlBit  = 8'h40;

  typedef enum logic [1:0] {
    NumOff      = 2'd0,
    NumAll      = 2'd1,
    NumNonEmpty = 2'd2
  } num_mode_e;

  typedef enum logic [2:0] {
    RegNumberMode     = 3'd0,
    RegShowEnds       = 3'd1,
    RegSqueezeBlank   = 3'd2,
    RegShowTabs       = 3'd3,
    RegShowNonprint   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [1:0] number_mode;
    logic       show_ends;
    logic       squeeze_blank;
    logic       show_tabs;
    logic       show_nonprinting;
  } cfg_t;

  typedef logic [NumDigits-1:0][3:0] bcd_t;

  // One rendered item: optional number field, then one to four bytes.
  typedef struct packed {
    logic                        num_en;
    logic [NumDigits-1:0][7:0]   num_chars;
    logic [SfxMax-1:0][7:0]      sfx;
    logic [SfxLenW-1:0]          sfx_len;
  } job_t;

endpackage

@@ design/tlef_in_if.sv @@
// tlef_in_if: input channel of the filter, one raw text byte per item.
// Standalone; no package needed.
interface tlef_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;
  modport source (output valid, data_byte, file_start, input ready);
  modport sink   (input valid, data_byte, file_start, output ready);
endinterface

@@ design/tlef_out_if.sv @@
// tlef_out_if: output channel of the filter, one rendered byte per item.
// Standalone; no package needed.
interface tlef_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

@@ design/tlef_cfg_if.sv @@
// tlef_cfg_if: register write channel, carrying register index and data.
// Standalone; no package needed.
interface tlef_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/tlef_queue.sv @@
// tlef_queue: small FIFO of rendered jobs between front and back.
// Depends on tlef_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tlef_queue import tlef_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_data_o
);

  job_t                entries_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] count_q;
  logic                push, pop;

  assign push_ready_o = (count_q != FifoCntW'(FifoDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      if (push && !pop)      count_q <= count_q + FifoCntW'(1);
      else if (pop && !push) count_q <= count_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entries_q[wr_ptr_q] <= push_data_i;
  end

  `TLEF_ASSERT_NR(a_count_bound, clk_i, count_q <= FifoCntW'(FifoDepth), "queue overfilled")
  `TLEF_ASSERT(a_push_grows, clk_i, rst_ni, push && !pop |=> count_q == $past(count_q) + FifoCntW'(1), "push lost")
  `TLEF_ASSERT(a_pop_shrinks, clk_i, rst_ni, pop && !push |=> count_q == $past(count_q) - FifoCntW'(1), "pop lost")

endmodule

@@ design/tlef_front.sv @@
// tlef_front: accepts raw bytes, keeps line state and renders each into a job.
// Depends on tlef_pkg and tlef_in_if.
module tlef_front import tlef_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  tlef_in_if.sink       in_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output job_t          job_o
);

  localparam bcd_t BcdOne = bcd_t'(1);

  bcd_t       cnt_q, cnt, cnt_d;
  logic       als_q, plb_q, als, plb;
  logic       nl, squeeze, num_en, accept, lead;
  logic [6:0] lo;
  char_t      t0, t1;
  logic       t_two;

  // Saturating BCD increment: all nines hold.
  function automatic bcd_t bcd_inc(bcd_t v);
    bcd_t r;
    logic carry;
    logic sat;
    r     = v;
    carry = 1'b1;
    sat   = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      if (v[i] != 4'd9) sat = 1'b0;
    end
    for (int i = 0; i < NumDigits; i++) begin
      if (carry) begin
        if (v[i] == 4'd9) begin
          r[i] = 4'd0;
        end else begin
          r[i]  = v[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return sat ? v : r;
  endfunction

  always_comb begin
    cnt     = in_i.file_start ? BcdOne : cnt_q;
    als     = in_i.file_start | als_q;
    plb     = !in_i.file_start && plb_q;
    nl      = (in_i.data_byte == ChNl);
    squeeze = als && nl && cfg_i.squeeze_blank && plb;
    num_en  = als && ((cfg_i.number_mode == NumAll) ||
                      ((cfg_i.number_mode == NumNonEmpty) && !nl));
    cnt_d   = (num_en && !squeeze) ? bcd_inc(cnt) : cnt;
  end

  always_comb begin
    // Number field, right-aligned with leading blanks.
    lead          = 1'b1;
    job_o.num_en  = num_en;
    job_o.num_chars = '0;
    for (int i = NumDigits - 1; i >= 0; i--) begin
      if (cnt[i] != 4'd0 || i == 0) lead = 1'b0;
      job_o.num_chars[i] = lead ? ChSpace : (ChZero | {4'b0000, cnt[i]});
    end

    // Byte rendering: caret pair for controls, M- prefix for high bytes.
    lo    = in_i.data_byte[6:0];
    t0    = {1'b0, lo};
    t1    = '0;
    t_two = 1'b0;
    if (lo < 7'd32) begin
      t0    = ChCaret;
      t1    = {1'b0, lo} | CtrlBit;
      t_two = 1'b1;
    end else if (lo == 7'h7F) begin
      t0    = ChCaret;
      t1    = ChQuery;
      t_two = 1'b1;
    end
    job_o.sfx     = '0;
    job_o.sfx_len = SfxLenW'(1);
    if (nl) begin
      if (cfg_i.show_ends) begin
        job_o.sfx[0]  = ChDollar;
        job_o.sfx[1]  = ChNl;
        job_o.sfx_len = SfxLenW'(2);
      end else begin
        job_o.sfx[0] = ChNl;
      end
    end else if (in_i.data_byte == ChTab) begin
      if (cfg_i.show_tabs) begin
        job_o.sfx[0]  = ChCaret;
        job_o.sfx[1]  = ChUpperI;
        job_o.sfx_len = SfxLenW'(2);
      end else begin
        job_o.sfx[0] = ChTab;
      end
    end else if (cfg_i.show_nonprinting) begin
      if (in_i.data_byte[7]) begin
        job_o.sfx[0]  = ChUpperM;
        job_o.sfx[1]  = ChDash;
        job_o.sfx[2]  = t0;
        job_o.sfx[3]  = t1;
        job_o.sfx_len = t_two ? SfxLenW'(4) : SfxLenW'(3);
      end else begin
        job_o.sfx[0]  = t0;
        job_o.sfx[1]  = t1;
        job_o.sfx_len = t_two ? SfxLenW'(2) : SfxLenW'(1);
      end
    end else begin
      job_o.sfx[0] = in_i.data_byte;
    end
  end

  assign in_i.ready  = job_ready_i;
  assign accept      = in_i.valid && job_ready_i;
  assign job_valid_o = in_i.valid && !squeeze;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= BcdOne;
      als_q <= 1'b1;
      plb_q <= 1'b0;
    end else if (accept) begin
      cnt_q <= cnt_d;
      als_q <= nl;
      plb_q <= als ? nl : plb;
    end
  end

endmodule

@@ design/tlef_back.sv @@
// tlef_back: plays each queued job out as one byte per cycle while the sink is ready.
// Depends on tlef_pkg and tlef_out_if.
module tlef_back import tlef_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  job_t          job_i,
  tlef_out_if.source    out_o
);

  job_t                job_q;
  logic                busy_q, busy_d;
  logic [PosW-1:0]     pos_q, pos_d, sfx_pos;
  logic [DigIdxW-1:0]  dig_idx;
  logic                in_num, in_tab, last, fire, load;

  always_comb begin
    in_num  = job_q.num_en && (pos_q < PosW'(NumDigits));
    in_tab  = job_q.num_en && (pos_q == PosW'(NumDigits));
    sfx_pos = job_q.num_en ? pos_q - PosW'(NumDigits + 1) : pos_q;
    dig_idx = DigIdxW'(PosW'(NumDigits - 1) - pos_q);
    last    = !in_num && !in_tab && (sfx_pos + PosW'(1) == PosW'(job_q.sfx_len));
  end

  assign out_o.valid       = busy_q;
  assign out_o.last_of_run = last;
  assign out_o.out_byte    = in_num ? job_q.num_chars[dig_idx] :
                             in_tab ? ChTab : job_q.sfx[sfx_pos[SfxIdxW-1:0]];

  assign fire        = busy_q && out_o.ready;
  assign load        = job_valid_i && (!busy_q || (fire && last));
  assign job_ready_o = load;

  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    if (load) begin
      busy_d = 1'b1;
      pos_d  = '0;
    end else if (fire && last) begin
      busy_d = 1'b0;
      pos_d  = '0;
    end else if (fire) begin
      pos_d = pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) job_q <= job_i;
  end

endmodule

@@ design/text_line_number_escape_filter.sv @@
// Line-numbering escape filter: one raw byte in, zero to eleven rendered bytes out.
// With the back end idle, an accepted byte passes the queue and the back end's job register
// before its first output byte is offered. Throughput: one output byte per cycle while the sink
// is ready, 1 to NumDigits+5 per item; input is taken every cycle while the 4-deep queue has room.
// Reset: options clear, counter goes to one, line start set, blank-line flag clear.
// Depends on tlef_pkg, the three channel interfaces, tlef_front, tlef_queue, tlef_back.
module text_line_number_escape_filter import tlef_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlef_cfg_if.sink    cfg_i,
  tlef_in_if.sink     in_i,
  tlef_out_if.source  out_o
);

  cfg_t cfg_q;
  logic job_valid, job_ready, q_valid, q_ready;
  job_t job, q_job;

  // The user must write options only while idle; the block does not enforce this and always takes the write.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegNumberMode:   cfg_q.number_mode      <= cfg_i.data[1:0];
        RegShowEnds:     cfg_q.show_ends        <= cfg_i.data[0];
        RegSqueezeBlank: cfg_q.squeeze_blank    <= cfg_i.data[0];
        RegShowTabs:     cfg_q.show_tabs        <= cfg_i.data[0];
        RegShowNonprint: cfg_q.show_nonprinting <= cfg_i.data[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Front: accept, advance line state, render the item into a job.
  // Squeezed blank lines are accepted but push nothing.
  tlef_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  // Queue: absorb the occasional long expansion so the input keeps moving.
  tlef_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_job)
  );

  // Back: hold the current job and step through its bytes as the sink takes them.
  tlef_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .out_o       (out_o)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking testbench for the line-numbering escape filter.
// Depends on tlef_pkg, the three channel interfaces and the filter itself;
// a built-in rendering predictor checks every output byte in order.
module tb_top import tlef_pkg::*; ();

  // Timing of the run
  localparam int HalfPeriod    = 5;
  localparam int ResetCycles   = 8;
  localparam int SettleCycles  = 8;    // after the last owed byte, before the script moves on
  localparam int TailCycles    = 12;   // after the last byte, before the verdict
  localparam int HoldCycles    = 150;  // long receiver hold-off
  localparam int HoldAtFirst   = 100;  // output counts that start a long hold-off
  localparam int HoldAtSecond  = 400;
  localparam int WatchdogLimit = 2000;
  localparam int ReportLimit   = 10;

  // Byte values the package leaves out
  localparam char_t ChDel  = 8'h7F;
  localparam char_t ChHigh = 8'h80;

  // Register index past the end of the list; writes to it must be ignored
  localparam logic [2:0] RegBeyond = 3'd5;

  typedef enum logic [1:0] {
    FeedByte,
    FeedReg,
    FeedSettle
  } feed_kind_e;

  // One entry of the stimulus script: a text byte, a register write or a pause
  typedef struct {
    feed_kind_e kind;
    char_t      data;
    logic       file_start;
    logic [2:0] idx;
  } feed_entry_t;

  typedef struct packed {
    char_t out_byte;
    logic  last_of_run;
  } rendered_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tlef_in_if  in_if ();
  tlef_out_if out_if ();
  tlef_cfg_if cfg_if ();

  text_line_number_escape_filter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Stimulus script, consumed by the driver
  feed_entry_t feed_q[$];
  // Rendered bytes still owed by the filter, oldest first
  rendered_t   render_q[$];

  // Predictor state: options and line bookkeeping
  cfg_t opts;
  bcd_t line_bcd;
  logic line_start;
  logic prev_blank;

  // Driver state
  int   gap_left;
  int   settle_left;
  logic settling;
  logic feed_done;
  bit   in_burst;

  // Monitor state
  int   stall_left;
  int   results_seen;
  logic hold_active;
  bit   out_burst;

  int   fail_count = 0;
  int   idle_cycles;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void apply_reg(logic [2:0] idx, char_t val);
    case (idx)
      RegNumberMode:   opts.number_mode      = val[1:0];
      RegShowEnds:     opts.show_ends        = val[0];
      RegSqueezeBlank: opts.squeeze_blank    = val[0];
      RegShowTabs:     opts.show_tabs        = val[0];
      RegShowNonprint: opts.show_nonprinting = val[0];
      default: ;
    endcase
  endfunction

  function automatic void push_byte(char_t b);
    render_q.push_back('{out_byte: b, last_of_run: 1'b0});
  endfunction

  // Emit the counter right-aligned with leading blanks, then a tab
  function automatic void push_line_number();
    logic lead;
    lead = 1'b1;
    for (int i = NumDigits - 1; i >= 0; i--) begin
      if (line_bcd[i] != 4'd0 || i == 0) lead = 1'b0;
      push_byte(lead ? ChSpace : ChZero + char_t'(line_bcd[i]));
    end
    push_byte(ChTab);
  endfunction

  // Decimal increment; the counter sticks once every digit is nine
  function automatic void bump_line_count();
    logic all_nine;
    logic carry;
    all_nine = 1'b1;
    for (int i = 0; i < NumDigits; i++)
      if (line_bcd[i] != 4'd9) all_nine = 1'b0;
    if (!all_nine) begin
      carry = 1'b1;
      for (int i = 0; i < NumDigits; i++) begin
        if (carry) begin
          if (line_bcd[i] == 4'd9) begin
            line_bcd[i] = 4'd0;
          end else begin
            line_bcd[i] = line_bcd[i] + 4'd1;
            carry       = 1'b0;
          end
        end
      end
    end
  endfunction

  // Caret form of a seven-bit value: controls as ^X, delete as ^?
  function automatic void push_caret_form(logic [6:0] b);
    if (b < 7'd32) begin
      push_byte(ChCaret);
      push_byte(char_t'(b) | CtrlBit);
    end else if (char_t'(b) == ChDel) begin
      push_byte(ChCaret);
      push_byte(ChQuery);
    end else begin
      push_byte(char_t'(b));
    end
  endfunction

  // Work out every output byte that one accepted text byte must produce
  function automatic void predict_render(char_t c, logic file_start);
    logic      nl;
    rendered_t tail;
    nl = (c == ChNl);
    if (file_start) begin
      line_bcd    = '0;
      line_bcd[0] = 4'd1;
      line_start  = 1'b1;
      prev_blank  = 1'b0;
    end
    if (line_start) begin
      // A second empty line in a row vanishes without touching any state
      if (nl && opts.squeeze_blank && prev_blank) return;
      if (opts.number_mode == NumAll || (opts.number_mode == NumNonEmpty && !nl)) begin
        push_line_number();
        bump_line_count();
      end
      prev_blank = nl;
    end
    if (nl) begin
      if (opts.show_ends) push_byte(ChDollar);
      push_byte(ChNl);
    end else if (c == ChTab) begin
      if (opts.show_tabs) begin
        push_byte(ChCaret);
        push_byte(ChUpperI);
      end else begin
        push_byte(ChTab);
      end
    end else if (opts.show_nonprinting) begin
      if (c >= ChHigh) begin
        push_byte(ChUpperM);
        push_byte(ChDash);
      end
      push_caret_form(c[6:0]);
    end else begin
      push_byte(c);
    end
    line_start = nl;
    tail = render_q.pop_back();
    tail.last_of_run = 1'b1;
    render_q.push_back(tail);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus script
  // ---------------------------------------------------------------------------

  function automatic void queue_byte(char_t c, logic file_start);
    feed_q.push_back('{kind: FeedByte, data: c, file_start: file_start, idx: '0});
  endfunction

  function automatic void queue_reg(logic [2:0] idx, char_t val);
    feed_q.push_back('{kind: FeedReg, data: val, file_start: 1'b0, idx: idx});
  endfunction

  function automatic void queue_settle();
    feed_q.push_back('{kind: FeedSettle, data: '0, file_start: 1'b0, idx: '0});
  endfunction

  // Write every register; the unused upper data bits carry noise
  function automatic void queue_options(logic [1:0] mode, logic ends, logic squeeze,
                                        logic tabs, logic nonprint);
    queue_reg(RegNumberMode,   {6'($urandom), mode});
    queue_reg(RegShowEnds,     {7'($urandom), ends});
    queue_reg(RegSqueezeBlank, {7'($urandom), squeeze});
    queue_reg(RegShowTabs,     {7'($urandom), tabs});
    queue_reg(RegShowNonprint, {7'($urandom), nonprint});
  endfunction

  // Mostly printable text, with tabs, controls, delete and high bytes mixed in
  function automatic char_t pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)      return char_t'($urandom_range(33, 126));
    else if (r < 58) return ChSpace;
    else if (r < 68) return ChTab;
    else if (r < 78) return char_t'($urandom_range(0, 31));
    else if (r < 82) return ChDel;
    else             return char_t'($urandom_range(128, 255));
  endfunction

  // Line-shaped random text: real lines, runs of empty lines and raw noise
  function automatic void queue_text(int quota);
    int added;
    int r;
    int len;
    added = 0;
    while (added < quota) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        queue_byte(char_t'($urandom), 1'($urandom_range(0, 9) == 0));
        added++;
      end else if (r < 22) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          queue_byte(ChNl, i == 0 && $urandom_range(0, 9) == 0);
        added += len;
      end else begin
        len = $urandom_range(1, 9);
        for (int i = 0; i < len; i++)
          queue_byte(pick_text_byte(), i == 0 && $urandom_range(0, 19) == 0);
        queue_byte(ChNl, 1'b0);
        added += len + 1;
      end
    end
  endfunction

  function automatic void build_stimulus();
    // Directed: every rendering path with all options on, then numbering of
    // non-empty lines only with raw bytes passed through
    queue_options(NumAll, 1'b1, 1'b1, 1'b1, 1'b1);
    queue_byte(8'h41, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h1F, 1'b0);
    queue_byte(ChDel, 1'b0);
    queue_byte(ChHigh, 1'b0);
    queue_byte(ChHigh | ChTab, 1'b0);
    queue_byte(ChHigh | ChNl, 1'b0);
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'hA0, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(ChTab, 1'b0);
    queue_byte(ChNl, 1'b0);
    queue_byte(ChNl, 1'b0);
    queue_byte(ChNl, 1'b0);   // squeezed: no output at all
    queue_byte(ChSpace, 1'b0);
    queue_byte(8'h7E, 1'b0);
    queue_byte(ChNl, 1'b0);
    queue_settle();
    queue_options(NumNonEmpty, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_reg(RegBeyond, 8'hFF);
    queue_byte(ChNl, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(ChTab, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(ChNl, 1'b0);
    queue_byte(ChNl, 1'b1);

    // Random: all options off, then the unused numbering mode with all else on, then five phases of random options
    queue_settle();
    queue_options(NumOff, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_text(55);
    queue_settle();
    queue_options(2'd3, 1'b1, 1'b1, 1'b1, 1'b1);
    queue_text(55);
    for (int p = 0; p < 5; p++) begin
      queue_settle();
      queue_options(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                    1'($urandom), 1'($urandom));
      queue_text(27);
      // pause mid-phase until every owed byte is out, no write after it
      if (p == 1) queue_settle();
      queue_text(28);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feeds text bytes and register writes from the script
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic        nxt_in_valid;
    logic        nxt_cfg_valid;
    feed_entry_t ent;
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.data_byte  <= '0;
      in_if.file_start <= 1'b0;
      cfg_if.valid     <= 1'b0;
      cfg_if.index     <= '0;
      cfg_if.data      <= '0;
      gap_left         <= 0;
      settle_left      <= 0;
      settling         <= 1'b0;
      feed_done        <= 1'b0;
      in_burst          = 1'b0;
      // predictor follows the block's reset
      opts              = '0;
      line_bcd          = '0;
      line_bcd[0]       = 4'd1;
      line_start        = 1'b1;
      prev_blank        = 1'b0;
    end else begin
      nxt_in_valid  = in_if.valid;
      nxt_cfg_valid = cfg_if.valid;
      // Predict on the accepting edge so expectations are queued before outputs
      if (in_if.valid && in_if.ready) begin
        predict_render(in_if.data_byte, in_if.file_start);
        nxt_in_valid = 1'b0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        apply_reg(cfg_if.index, cfg_if.data);
        nxt_cfg_valid = 1'b0;
      end
      if (!nxt_in_valid && !nxt_cfg_valid) begin
        if (settling) begin
          // hold until the filter has nothing left, then let it go quiet
          if (render_q.size() != 0)  settle_left <= SettleCycles;
          else if (settle_left == 0) settling    <= 1'b0;
          else                       settle_left <= settle_left - 1;
        end else if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (feed_q.size() != 0) begin
          ent = feed_q.pop_front();
          case (ent.kind)
            FeedByte: begin
              in_if.data_byte  <= ent.data;
              in_if.file_start <= ent.file_start;
              nxt_in_valid      = 1'b1;
              // flip between bursts and gappy stretches now and then; keep
              // the input full while the receiver is held off
              if ($urandom_range(0, 24) == 0) in_burst = !in_burst;
              gap_left <= (in_burst || hold_active) ? 0 : $urandom_range(0, 19);
            end
            FeedReg: begin
              cfg_if.index  <= ent.idx;
              cfg_if.data   <= ent.data;
              nxt_cfg_valid  = 1'b1;
            end
            default: begin
              settling    <= 1'b1;
              settle_left <= SettleCycles;
            end
          endcase
        end else begin
          feed_done <= 1'b1;
        end
      end
      in_if.valid  <= nxt_in_valid;
      cfg_if.valid <= nxt_cfg_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: drives ready with random stalls and checks every output byte
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic      nxt_ready;
    rendered_t want;
    int        draw;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
      results_seen <= 0;
      hold_active  <= 1'b0;
      out_burst     = 1'b0;
    end else begin
      nxt_ready = out_if.ready;
      if (out_if.valid && out_if.ready) begin
        if (render_q.size() == 0) begin
          if (fail_count < ReportLimit)
            $display("unexpected output byte %h last %b at %0t",
                     out_if.out_byte, out_if.last_of_run, $realtime);
          fail_count++;
        end else begin
          want = render_q.pop_front();
          if (out_if.out_byte !== want.out_byte ||
              out_if.last_of_run !== want.last_of_run) begin
            if (fail_count < ReportLimit)
              $display("output mismatch at %0t: expected byte %h last %b, got byte %h last %b",
                       $realtime, want.out_byte, want.last_of_run,
                       out_if.out_byte, out_if.last_of_run);
            fail_count++;
          end
        end
        results_seen <= results_seen + 1;
        if (results_seen + 1 == HoldAtFirst || results_seen + 1 == HoldAtSecond) begin
          // long hold-off: the filter's queue fills and it stops taking input
          stall_left  <= HoldCycles;
          hold_active <= 1'b1;
          nxt_ready    = 1'b0;
        end else begin
          if ($urandom_range(0, 24) == 0) out_burst = !out_burst;
          draw = out_burst ? 0 : $urandom_range(0, 19);
          if (draw != 0) begin
            stall_left <= draw;
            nxt_ready   = 1'b0;
          end
        end
      end else if (!out_if.ready) begin
        if (stall_left <= 1) begin
          stall_left  <= 0;
          hold_active <= 1'b0;
          nxt_ready    = 1'b1;
        end else begin
          stall_left <= stall_left - 1;
        end
      end
      out_if.ready <= nxt_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: give up after a long stretch with no handshake on any channel
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Run control: reset, wait for the script to drain, give the verdict
  // ---------------------------------------------------------------------------

  initial begin : run_control
    rst_ni <= 1'b0;
    build_stimulus();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!feed_done) @(posedge clk_i);
    while (render_q.size() != 0) @(posedge clk_i);
    // let any late or stray output show up
    repeat (TailCycles) @(posedge clk_i);
    if (render_q.size() != 0) begin
      $display("%0d expected output bytes never arrived", render_q.size());
      fail_count += render_q.size();
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/tlef_pkg.sv
design/tlef_in_if.sv
design/tlef_out_if.sv
design/tlef_cfg_if.sv
design/tlef_queue.sv
design/tlef_front.sv
design/tlef_back.sv
design/text_line_number_escape_filter.sv
tb/sv/tb_top.sv
